@@ hdl/drp_pkg.sv @@
// ---------------------------------------------------------------------------
// drp_pkg: shared types and constants for disparity reprojection
// Word layouts, register map, fixed-point widths.
// ---------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;

    localparam int MAG_W   = 33;   // numerator magnitude, before the 2^22 scale
    localparam int DIV_W   = 42;   // |w| in Q.30
    localparam int QUO_W   = 32;   // quotient bits produced by the divider
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = 4;

    localparam logic [2:0] REG_CX  = 3'd0;
    localparam logic [2:0] REG_CY  = 3'd1;
    localparam logic [2:0] REG_FOC = 3'd2;
    localparam logic [2:0] REG_IB  = 3'd3;
    localparam logic [2:0] REG_WOT = 3'd4;

    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [7:0]  disparity;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [23:0]        packed_color;
        logic               weight_fault;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] center_x_offset;
        logic signed [31:0] center_y_offset;
        logic [31:0]        focal_length;
        logic signed [31:0] inverse_baseline;
        logic signed [31:0] weight_offset_term;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0] mag_x;
        logic             neg_x;
        logic [MAG_W-1:0] mag_y;
        logic             neg_y;
        logic [MAG_W-1:0] mag_z;
        logic             neg_z;
        logic [DIV_W-1:0] w_mag;
        logic             w_neg;
        logic             w_zero;
        logic [23:0]      color;
    } q_item_t;

endpackage

`default_nettype wire

@@ hdl/drp_front.sv @@
// ---------------------------------------------------------------------------
// drp_front: input stage
// Accepts pixels, drops unmatched ones, forms weight and numerators.
// ---------------------------------------------------------------------------
`default_nettype none

module drp_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire drp_pkg::cfg_t            cfg,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire drp_pkg::in_word_t        s_data,
    input  wire logic [drp_pkg::CNT_W-1:0] fifo_count,
    output logic                          push,
    output drp_pkg::q_item_t              push_item
);

    localparam int CNT_W_L = drp_pkg::CNT_W;

    logic                   v1_reg, v2_reg, v3_reg;
    drp_pkg::in_word_t      px_reg;
    logic                   keep2_reg, keep3_reg;
    logic signed [40:0]     prod_reg;
    logic signed [33:0]     nx_reg, ny_reg;
    logic [23:0]            col2_reg;
    drp_pkg::q_item_t       item_reg;

    logic                   keep1;
    logic signed [41:0]     w;
    logic [41:0]            w_abs;
    logic [33:0]            nx_abs, ny_abs;
    logic [CNT_W_L-1:0]     busy;

    // credits: queue entries plus words still in flight here
    assign busy = fifo_count + CNT_W_L'(v1_reg) + CNT_W_L'(v2_reg) + CNT_W_L'(v3_reg);
    assign s_ready = (busy < CNT_W_L'(drp_pkg::FIFO_DEPTH));

    assign keep1 = (px_reg.disparity != 8'd0)
                && ({5'd0, px_reg.column} < 17'(drp_pkg::MAX_COLUMNS))
                && ({5'd0, px_reg.row} < 17'(drp_pkg::MAX_ROWS));

    assign w      = 42'(cfg.weight_offset_term) - 42'(prod_reg);
    assign w_abs  = w[41] ? -w : w;
    assign nx_abs = nx_reg[33] ? 34'(-nx_reg) : 34'(nx_reg);
    assign ny_abs = ny_reg[33] ? 34'(-ny_reg) : 34'(ny_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= s_valid && s_ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            px_reg <= s_data;
        end
        keep2_reg <= keep1;
        prod_reg  <= $signed({1'b0, px_reg.disparity}) * cfg.inverse_baseline;
        nx_reg    <= $signed({2'b00, px_reg.column, 16'd0}) + 34'(cfg.center_x_offset);
        ny_reg    <= $signed({2'b00, px_reg.row, 16'd0}) + 34'(cfg.center_y_offset);
        col2_reg  <= {px_reg.red, px_reg.green, px_reg.blue};

        keep3_reg       <= keep2_reg;
        item_reg.mag_x  <= nx_abs[32:0];
        item_reg.neg_x  <= nx_reg[33];
        item_reg.mag_y  <= ny_abs[32:0];
        item_reg.neg_y  <= ny_reg[33];
        item_reg.mag_z  <= {1'b0, cfg.focal_length};
        item_reg.neg_z  <= 1'b1;
        item_reg.w_mag  <= w_abs;
        item_reg.w_neg  <= w[41];
        item_reg.w_zero <= (w == 42'sd0);
        item_reg.color  <= col2_reg;
    end

    assign push      = v3_reg && keep3_reg;
    assign push_item = item_reg;

endmodule

`default_nettype wire

@@ hdl/drp_fifo.sv @@
// ---------------------------------------------------------------------------
// drp_fifo: short queue between front and back
// Register-based, fall-through read.
// ---------------------------------------------------------------------------
`default_nettype none

module drp_fifo (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      push,
    input  wire drp_pkg::q_item_t          push_item,
    input  wire logic                      pop,
    output logic                           not_empty,
    output drp_pkg::q_item_t               head,
    output logic [drp_pkg::CNT_W-1:0]      count
);

    drp_pkg::q_item_t                 mem_reg [drp_pkg::FIFO_DEPTH];
    logic [drp_pkg::FIFO_AW-1:0]      wr_reg, rd_reg;
    logic [drp_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             do_pop;

    assign not_empty = (cnt_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_reg];
    assign count     = cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/drp_div.sv @@
// ---------------------------------------------------------------------------
// drp_div: pipelined signed divide with saturation
// (mag << 22) / dmag, one quotient bit per stage, truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module drp_div (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [drp_pkg::MAG_W-1:0]   mag,
    input  wire logic                        neg,
    input  wire logic [drp_pkg::DIV_W-1:0]   dmag,
    output logic [31:0]                      result
);

    localparam int NS = drp_pkg::QUO_W;
    localparam int DW = drp_pkg::DIV_W;

    logic [DW-1:0]  rem_reg  [NS+1];
    logic [31:0]    bits_reg [NS+1];
    logic [31:0]    q_reg    [NS+1];
    logic [DW-1:0]  d_reg    [NS+1];
    logic           ovf_reg  [NS+1];
    logic           neg_reg  [NS+1];
    logic           zero_reg [NS+1];

    logic [31:0] q;

    always_ff @(posedge aclk) begin
        logic [DW:0] r2;
        if (en) begin
            // top of the scaled numerator already >= divisor: quotient >= 2^32
            rem_reg[0]  <= DW'(mag[32:10]);
            bits_reg[0] <= {mag[9:0], 22'd0};
            q_reg[0]    <= '0;
            d_reg[0]    <= dmag;
            ovf_reg[0]  <= ({19'd0, mag[32:10]} >= dmag);
            neg_reg[0]  <= neg;
            zero_reg[0] <= (mag == '0);
            for (int k = 1; k <= NS; k++) begin
                r2 = {rem_reg[k-1], bits_reg[k-1][31]};
                if (r2 >= {1'b0, d_reg[k-1]}) begin
                    rem_reg[k] <= DW'(r2 - {1'b0, d_reg[k-1]});
                    q_reg[k]   <= {q_reg[k-1][30:0], 1'b1};
                end else begin
                    rem_reg[k] <= r2[DW-1:0];
                    q_reg[k]   <= {q_reg[k-1][30:0], 1'b0};
                end
                bits_reg[k] <= {bits_reg[k-1][30:0], 1'b0};
                d_reg[k]    <= d_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    assign q = q_reg[NS];

    always_comb begin
        if (zero_reg[NS]) begin
            result = '0;
        end else if (ovf_reg[NS]) begin
            result = neg_reg[NS] ? drp_pkg::S32_MIN : drp_pkg::S32_MAX;
        end else if (neg_reg[NS]) begin
            result = (q > drp_pkg::S32_MIN) ? drp_pkg::S32_MIN : (~q + 32'd1);
        end else begin
            result = q[31] ? drp_pkg::S32_MAX : q;
        end
    end

endmodule

`default_nettype wire

@@ hdl/drp_back.sv @@
// ---------------------------------------------------------------------------
// drp_back: divider pipeline and output register
// Three divide lanes share one stall; color and fault ride alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module drp_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_not_empty,
    input  wire drp_pkg::q_item_t   q_head,
    output logic                    pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output drp_pkg::out_word_t      m_data
);

    localparam int NS = drp_pkg::QUO_W;

    logic               en;
    logic               vld_reg   [NS+1];
    logic [23:0]        col_reg   [NS+1];
    logic               fault_reg [NS+1];
    logic               m_valid_reg, m_valid_next;
    drp_pkg::out_word_t m_data_reg;
    logic [31:0]        rx, ry, rz;

    assign en  = !m_valid_reg || m_ready;
    assign pop = en && q_not_empty;

    drp_div u_div_x (.aclk(aclk), .en(en), .mag(q_head.mag_x),
                     .neg(q_head.neg_x ^ q_head.w_neg), .dmag(q_head.w_mag), .result(rx));
    drp_div u_div_y (.aclk(aclk), .en(en), .mag(q_head.mag_y),
                     .neg(q_head.neg_y ^ q_head.w_neg), .dmag(q_head.w_mag), .result(ry));
    drp_div u_div_z (.aclk(aclk), .en(en), .mag(q_head.mag_z),
                     .neg(q_head.neg_z ^ q_head.w_neg), .dmag(q_head.w_mag), .result(rz));

    assign m_valid_next = en ? vld_reg[NS] : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NS; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (en) begin
                vld_reg[0] <= q_not_empty;
                for (int k = 1; k <= NS; k++) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg[0]   <= q_head.color;
            fault_reg[0] <= q_head.w_zero;
            for (int k = 1; k <= NS; k++) begin
                col_reg[k]   <= col_reg[k-1];
                fault_reg[k] <= fault_reg[k-1];
            end
            m_data_reg.point_x      <= rx;
            m_data_reg.point_y      <= ry;
            m_data_reg.point_z      <= rz;
            m_data_reg.packed_color <= col_reg[NS];
            m_data_reg.weight_fault <= fault_reg[NS];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ hdl/disparity_to_point_reprojection.sv @@
// ---------------------------------------------------------------------------
// disparity_to_point_reprojection: stereo disparity to 3-D point
// Turns each matched pixel into a saturated Q24.8 point plus packed color.
// ---------------------------------------------------------------------------
// Usage:
//  - s_ channel: one pixel word (disparity, column, row, blue, green, red).
//    Pixels with zero disparity produce no output word.
//  - m_ channel: point_x/y/z (Q24.8, saturated), packed color, weight_fault
//    set when the homogeneous weight is zero.
//  - cfg_ channel: register index + 32-bit data, always ready; write only
//    while idle. Indexes above 4 are ignored.
//  - Throughput: one pixel per clock sustained while m_ready stays high.
//  - Path: after the accepting edge a word passes two more front stages,
//    one queue write, 33 divider stages (overflow check plus 32 quotient
//    bits) and the output register before m_valid rises; the bit-per-stage
//    divider makes up most of that depth.
//  - Stall: when m_ready is low with a word held, the divider pipeline
//    freezes; the front keeps accepting until the 8-word queue's credits
//    run out, then s_ready drops.
//  - Reset (aresetn low, synchronous): registers return to defaults
//    (weight offset 1.0, others 0), pipeline and queue empty.
// ---------------------------------------------------------------------------
`default_nettype none

module disparity_to_point_reprojection (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire drp_pkg::in_word_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output drp_pkg::out_word_t       m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    drp_pkg::cfg_t                   cfg_reg;
    logic                            push, pop, q_not_empty;
    drp_pkg::q_item_t                push_item, q_head;
    logic [drp_pkg::CNT_W-1:0]       fifo_count;

    assign cfg_ready = 1'b1;

    // register file; out-of-range index writes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x_offset    <= '0;
            cfg_reg.center_y_offset    <= '0;
            cfg_reg.focal_length       <= '0;
            cfg_reg.inverse_baseline   <= '0;
            cfg_reg.weight_offset_term <= 32'sh4000_0000;
        end else if (cfg_valid && (cfg_index[7:3] == 5'd0)) begin
            unique case (cfg_index[2:0])
                drp_pkg::REG_CX:  cfg_reg.center_x_offset    <= cfg_data;
                drp_pkg::REG_CY:  cfg_reg.center_y_offset    <= cfg_data;
                drp_pkg::REG_FOC: cfg_reg.focal_length       <= cfg_data;
                drp_pkg::REG_IB:  cfg_reg.inverse_baseline   <= cfg_data;
                drp_pkg::REG_WOT: cfg_reg.weight_offset_term <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept, drop unmatched, weight and numerators
    drp_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .fifo_count(fifo_count), .push(push), .push_item(push_item)
    );

    // queue decouples front from the stallable back
    drp_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_item(push_item),
        .pop(pop), .not_empty(q_not_empty), .head(q_head), .count(fifo_count)
    );

    // back: dividers, saturation, output register
    drp_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_not_empty(q_not_empty),
        .q_head(q_head), .pop(pop), .m_valid(m_valid), .m_ready(m_ready),
        .m_data(m_data)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench for disparity_to_point_reprojection
// Drives pixel words with random gaps, predicts each point in fixed point,
// and checks every output word in order against the prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    // register indexes (one past the last is a bad index)
    typedef enum logic [7:0] {
        IDX_CX = 8'd0, IDX_CY = 8'd1, IDX_FOC = 8'd2, IDX_IB = 8'd3,
        IDX_WOT = 8'd4, IDX_BAD = 8'd5
    } reg_idx_e;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    drp_pkg::in_word_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    drp_pkg::out_word_t  m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;     // forces the receiver to stall for a long stretch

    always #5 aclk = ~aclk;

    disparity_to_point_reprojection DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // -----------------------------------------------------------------------
    // point predictor and queue of pending points
    // -----------------------------------------------------------------------
    class point_scoreboard;
        drp_pkg::cfg_t regs;
        drp_pkg::out_word_t pending_points[$];

        function void reset_regs();
            regs = '0;
            regs.weight_offset_term = 32'sh4000_0000;
        endfunction

        function void write_reg(logic [7:0] idx, logic [31:0] val);
            case (idx)
                IDX_CX:  regs.center_x_offset    = val;
                IDX_CY:  regs.center_y_offset    = val;
                IDX_FOC: regs.focal_length       = val;
                IDX_IB:  regs.inverse_baseline   = val;
                IDX_WOT: regs.weight_offset_term = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] quotient_sat(longint num, longint w);
            longint q;
            if (w == 0) begin
                if (num > 0) return 32'h7fff_ffff;
                if (num < 0) return 32'h8000_0000;
                return 32'h0;
            end
            q = num / w;
            if (q > 64'sd2147483647) return 32'h7fff_ffff;
            if (q < -64'sd2147483648) return 32'h8000_0000;
            return q[31:0];
        endfunction

        // numerators fit in 56 bits, so 64-bit signed math stays exact
        function void note_pixel(drp_pkg::in_word_t px);
            longint w, nx, ny, nz;
            drp_pkg::out_word_t pt;
            if (px.disparity == 0) return;
            w  = longint'(regs.weight_offset_term)
               - longint'(px.disparity) * longint'(regs.inverse_baseline);
            nx = (longint'(px.column) * 65536 + longint'(regs.center_x_offset)) * 4194304;
            ny = (longint'(px.row) * 65536 + longint'(regs.center_y_offset)) * 4194304;
            nz = -(longint'({32'h0, regs.focal_length}) * 4194304);
            pt.point_x = quotient_sat(nx, w);
            pt.point_y = quotient_sat(ny, w);
            pt.point_z = quotient_sat(nz, w);
            pt.packed_color = {px.red, px.green, px.blue};
            pt.weight_fault = (w == 0);
            pending_points = {pending_points, pt};
        endfunction

        task check_point(drp_pkg::out_word_t got);
            drp_pkg::out_word_t want;
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected word", got.point_x, 32'h0);
                return;
            end
            want = pending_points.pop_front();
            if (got.point_x !== want.point_x) report_mismatch("point_x", got.point_x, want.point_x);
            if (got.point_y !== want.point_y) report_mismatch("point_y", got.point_y, want.point_y);
            if (got.point_z !== want.point_z) report_mismatch("point_z", got.point_z, want.point_z);
            if (got.packed_color !== want.packed_color)
                report_mismatch("packed_color", 32'(got.packed_color),
                                32'(want.packed_color));
            if (got.weight_fault !== want.weight_fault)
                report_mismatch("weight_fault", 32'(got.weight_fault),
                                32'(want.weight_fault));
        endtask
    endclass

    point_scoreboard sb = new();

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // gap-free stretches alternate with gappy ones
    bit burst_mode = 1'b0;

    // valid stays up after the word is taken; the next word's gap or an idle
    // point lowers it, so valid gets one update per clock at most
    task automatic send_pixel(input drp_pkg::in_word_t px);
        int g;
        g = burst_mode ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [31:0] val);
        s_valid   <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every pending point, then let zero-disparity words clear
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic drp_pkg::in_word_t rand_pixel();
        drp_pkg::in_word_t px;
        px = drp_pkg::in_word_t'(56'({$urandom, $urandom}));
        if ($urandom_range(0, 9) == 0) px.disparity = 8'd0;
        else if ($urandom_range(0, 9) == 0) px.disparity = 8'd255;
        return px;
    endfunction

    task automatic set_all(input logic [31:0] cx, cy, foc, ib, wot);
        write_cfg(IDX_CX, cx);
        write_cfg(IDX_CY, cy);
        write_cfg(IDX_FOC, foc);
        write_cfg(IDX_IB, ib);
        write_cfg(IDX_WOT, wot);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if ((i % 40) == 0) burst_mode = $urandom_range(0, 2) == 0;
            send_pixel(rand_pixel());
        end
    endtask

    // -----------------------------------------------------------------------
    // receiver: random ready with gaps, plus the forced hold-off
    // -----------------------------------------------------------------------
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end else begin
                g = gap_len();
                if (g == 0) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
            end
        end
    end

    // checker: sample accepted output words at the clock edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_point(m_data);
    end

    // watchdog: counts cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial begin
        drp_pkg::in_word_t px;
        sb.reset_regs();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: w = 1.0, all outputs zero except color
        px = '{8'd1, 12'd0, 12'd0, 8'hff, 8'h00, 8'haa};
        send_pixel(px);
        px = '{8'd0, 12'd5, 12'd5, 8'h11, 8'h22, 8'h33};   // no match
        send_pixel(px);
        wait_idle();

        // typical camera setup
        set_all(32'hFEC0_0000, 32'hFF10_0000, 32'h0258_0000, 32'h0080_0000, 32'h0);
        send_pixel('{8'd255, 12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff});
        send_pixel('{8'd1, 12'd0, 12'hfff, 8'h00, 8'h00, 8'h00});
        send_pixel('{8'd128, 12'd320, 12'd240, 8'h01, 8'h02, 8'h04});
        wait_idle();

        // zero weight: positive, negative and zero numerators
        set_all(32'h0, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0010);
        send_pixel('{8'd16, 12'd1, 12'd0, 8'h5a, 8'ha5, 8'h3c});
        send_pixel('{8'd16, 12'd0, 12'd7, 8'h00, 8'h00, 8'h00});
        wait_idle();
        write_cfg(IDX_FOC, 32'h0);
        write_cfg(IDX_BAD, 32'hdead_beef);   // ignored
        send_pixel('{8'd16, 12'd0, 12'd0, 8'h01, 8'h01, 8'h01});
        wait_idle();

        // tiny weights saturate; extreme register values
        set_all(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_pixel('{8'd255, 12'hfff, 12'd0, 8'h80, 8'h40, 8'h20});
        send_pixel('{8'd1, 12'd0, 12'hfff, 8'h00, 8'hff, 8'h00});
        wait_idle();
        set_all(32'h0, 32'h0, 32'h0001_0000, 32'h0000_0001, 32'h0000_0001);
        send_pixel('{8'd2, 12'hfff, 12'hfff, 8'h00, 8'h00, 8'h00});   // w = -1 lsb
        wait_idle();

        // random phases under several settings
        set_all(32'hFEC0_0000, 32'hFF10_0000, 32'h0258_0000, 32'h0080_0000, 32'h0);
        random_phase(130);

        // long receiver stall while the sender keeps offering words;
        // more words than the pipeline and queue hold, so s_ready drops
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                burst_mode = 1'b1;
                for (int i = 0; i < 80; i++) begin
                    px = rand_pixel();
                    px.disparity = px.disparity | 8'd1;
                    send_pixel(px);
                end
                s_valid <= 1'b0;
                burst_mode = 1'b0;
            end
        join
        wait_idle();

        for (int k = 0; k < 3; k++) begin
            set_all($urandom, $urandom, $urandom, $urandom >> $urandom_range(0, 24),
                    $urandom);
            random_phase(110);
            wait_idle();
        end

        wait_idle();
        if (mismatch_count == 0 && sb.pending_points.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

`default_nettype wire

@@ filelist.f @@
hdl/drp_pkg.sv
hdl/drp_front.sv
hdl/drp_fifo.sv
hdl/drp_div.sv
hdl/drp_back.sv
hdl/disparity_to_point_reprojection.sv
tb/tb_top.sv
